// File: design/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and codes for the handle slot table: command codes, status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hst_pkg;

	typedef enum logic [1:0] {
		CMD_PUT     = 2'd0,
		CMD_GET     = 2'd1,
		CMD_RELEASE = 2'd2
	} hst_op_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} hst_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic do_exec;
		logic mem_rd;
		logic load_get;
	} hst_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_get;
		logic out_free;
	} hst_stat_t;

endpackage

// File: design/hst_ram.sv
// ----------------------------------------------------------------------------
// hst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/hst_ctrl.sv
// ----------------------------------------------------------------------------
// hst_ctrl
// Sequencer for the handle slot table: takes an item, executes it, and for
// a get waits on the table read before handing the result to the output
// register.
// ----------------------------------------------------------------------------
module hst_ctrl
	import hst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  hst_stat_t stat,
	output hst_cmd_t  ctrl
);

	hst_state_t state_q;
	hst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.is_get) begin
					state_d = ST_READ;
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall       = 1'b0;
				ctrl.load_item = in_valid;
			end
			ST_EXEC: begin
				ctrl.do_exec = !stat.is_get && stat.out_free;
				ctrl.mem_rd  = stat.is_get;
			end
			ST_READ: begin
				ctrl.load_get = stat.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

// File: design/hst_dp.sv
// ----------------------------------------------------------------------------
// hst_dp
// Datapath of the handle slot table: item registers, used marks in flops
// with a lowest-free priority encoder, the address/length table RAM and the
// output register.
// ----------------------------------------------------------------------------
module hst_dp
	import hst_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hst_cmd_t    ctrl,
	output hst_stat_t   stat,
	input  logic [1:0]  command,
	input  logic [31:0] buffer_address,
	input  logic [31:0] buffer_length,
	input  logic [7:0]  handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  new_handle,
	output logic [31:0] found_address,
	output logic [31:0] found_length
);

	localparam int         IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [7:0] SLOT_MAX = 8'(SLOT_COUNT);

	hst_op_t              op_q;
	logic [31:0]          addr_q;
	logic [31:0]          len_q;
	logic [7:0]           handle_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic                 get_ok_q;
	logic                 out_valid_q;
	logic                 status_q;
	logic [7:0]           new_handle_q;
	logic [31:0]          found_address_q;
	logic [31:0]          found_length_q;

	logic             any_free;
	logic [IDX_W-1:0] free_idx;
	logic             handle_ok;
	logic [IDX_W-1:0] slot_idx;
	logic             put_ok;
	logic             put_fire;
	logic             rel_fire;
	logic             exec_status;
	logic [7:0]       exec_handle;
	logic [63:0]      rd_data;

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			op_q     <= hst_op_t'(command);
			addr_q   <= buffer_address;
			len_q    <= buffer_length;
			handle_q <= handle;
		end
	end

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign handle_ok = (handle_q != 8'd0) && (handle_q <= SLOT_MAX);
	assign slot_idx  = IDX_W'(handle_q - 8'd1);
	assign put_ok    = !((len_q != 32'd0) && (addr_q == 32'd0)) && any_free;

	always_comb begin
		put_fire    = 1'b0;
		rel_fire    = 1'b0;
		exec_status = STATUS_FAIL;
		exec_handle = 8'd0;
		case (op_q)
			CMD_PUT: begin
				put_fire = ctrl.do_exec && put_ok;
				if (put_ok) begin
					exec_status = STATUS_OK;
					exec_handle = 8'(free_idx) + 8'd1;
				end
			end
			CMD_RELEASE: begin
				rel_fire = ctrl.do_exec && handle_ok;
				if (handle_ok) begin
					exec_status = STATUS_OK;
				end
			end
			default: begin
				exec_status = STATUS_FAIL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (put_fire) begin
			used_q[free_idx] <= 1'b1;
		end else if (rel_fire) begin
			used_q[slot_idx] <= 1'b0;
		end
	end

	hst_ram #(
		.WIDTH(64),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (put_fire),
		.wr_addr (free_idx),
		.wr_data ({addr_q, len_q}),
		.rd_en   (ctrl.mem_rd),
		.rd_addr (slot_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (ctrl.mem_rd) begin
			get_ok_q <= handle_ok && used_q[slot_idx];
		end
	end

	assign stat.is_get   = (op_q == CMD_GET);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.do_exec || ctrl.load_get) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_exec) begin
			status_q        <= exec_status;
			new_handle_q    <= exec_handle;
			found_address_q <= 32'd0;
			found_length_q  <= 32'd0;
		end else if (ctrl.load_get) begin
			status_q        <= get_ok_q ? STATUS_OK : STATUS_FAIL;
			new_handle_q    <= 8'd0;
			found_address_q <= get_ok_q ? rd_data[63:32] : 32'd0;
			found_length_q  <= get_ok_q ? rd_data[31:0] : 32'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign new_handle    = new_handle_q;
	assign found_address = found_address_q;
	assign found_length  = found_length_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.do_exec || ctrl.load_get) |-> stat.out_free)
		else $error("result loaded over an item still waiting");

	a_put_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire |=> used_q[$past(free_idx)])
		else $error("claimed slot not marked used");

	a_handle_success: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (new_handle_q != 8'd0)) |-> (status_q == STATUS_OK))
		else $error("new handle given with failure status");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.do_exec && (ctrl.load_get || ctrl.mem_rd)))
		else $error("conflicting datapath commands");

endmodule

// File: design/handle_slot_table.sv
// ----------------------------------------------------------------------------
// handle_slot_table
// Fixed table of buffer slots handed out by handle (slot index plus one).
// ----------------------------------------------------------------------------
// One item at a time. A put, a release or an unknown command is written to
// the result register from the execute step once the output is free. A get
// goes on to a read step for the registered read of the address/length table
// RAM and is written from there. The next item is accepted in the cycle after
// the previous one has been written to the output register, even while that
// result still waits to be taken. A result still waiting in the output
// register holds the following item in its execute step, or a get in its read
// step, until it is taken. The lowest free slot comes from a priority encoder
// over the used marks, which sit in flops cleared by reset, so no clearing
// pass is needed after reset.
module handle_slot_table
	import hst_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] buffer_address,
	input  logic [31:0] buffer_length,
	input  logic [7:0]  handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  new_handle,
	output logic [31:0] found_address,
	output logic [31:0] found_length
);

	hst_cmd_t  ctrl;
	hst_stat_t stat;

	hst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	hst_dp #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.command        (command),
		.buffer_address (buffer_address),
		.buffer_length  (buffer_length),
		.handle         (handle),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.new_handle     (new_handle),
		.found_address  (found_address),
		.found_length   (found_length)
	);

endmodule
